// File: hdl/scle_pkg.sv
package scle_pkg;

   localparam int LINE_LENGTH = 128;
   localparam logic [7:0] LINE_LIMIT = 8'(LINE_LENGTH);
   localparam int NUM_TERMS = 3;
   localparam int KEY_COUNT = 54;
   localparam int MAP_DEPTH = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_WIDTH = 16;
   localparam int RSP_WIDTH = 24;
   localparam int RSP_USER_WIDTH = 3;

   localparam logic [7:0] SC_BACKSPACE   = 8'h0E;
   localparam logic [7:0] SC_TAB         = 8'h0F;
   localparam logic [7:0] SC_ENTER       = 8'h1C;
   localparam logic [7:0] SC_CTRL_DOWN   = 8'h1D;
   localparam logic [7:0] SC_CTRL_UP     = 8'h9D;
   localparam logic [7:0] SC_LSHIFT_DOWN = 8'h2A;
   localparam logic [7:0] SC_LSHIFT_UP   = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_DOWN = 8'h36;
   localparam logic [7:0] SC_RSHIFT_UP   = 8'hB6;
   localparam logic [7:0] SC_ALT_DOWN    = 8'h38;
   localparam logic [7:0] SC_ALT_UP      = 8'hB8;
   localparam logic [7:0] SC_SPACE       = 8'h39;
   localparam logic [7:0] SC_CAPS        = 8'h3A;
   localparam logic [7:0] SC_F1_DOWN     = 8'h3B;
   localparam logic [7:0] SC_F1_UP       = 8'hBB;
   localparam logic [7:0] SC_F2_DOWN     = 8'h3C;
   localparam logic [7:0] SC_F2_UP       = 8'hBC;
   localparam logic [7:0] SC_F3_DOWN     = 8'h3D;
   localparam logic [7:0] SC_F3_UP       = 8'hBD;
   localparam logic [7:0] SC_KEY_L       = 8'h26;
   localparam logic [7:0] SC_KEY_C       = 8'h2E;

   localparam logic [6:0] CH_SPACE = 7'h20;

   typedef enum logic [2:0] {
      EV_STORE     = 3'd0,
      EV_ERASE     = 3'd1,
      EV_LINE_DONE = 3'd2,
      EV_CLEAR     = 3'd3,
      EV_INTERRUPT = 3'd4,
      EV_SWITCH    = 3'd5
   } event_kind_type;

   // one classified request as it waits between front and back
   typedef struct packed {
      event_kind_type kind;
      logic [1:0]     term;
      logic [6:0]     chr;
      logic [7:0]     pos;
      logic           valid;
      logic           full;
      logic           halt;
      logic           is_append;
      logic           quad;
   } cmd_type;

   typedef struct packed {
      event_kind_type kind;
      logic [1:0]     term;
      logic [6:0]     chr;
      logic [7:0]     pos;
      logic           valid;
      logic           full;
      logic           halt;
      logic           last;
   } result_type;

   typedef struct packed {
      logic head_valid;
      logic can_push;
   } queue_status_type;

   // indexes past the key range read as zero
   localparam logic [6:0] PLAIN_MAP [0:MAP_DEPTH-1] = '{
      7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
      7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
      7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00,
      7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
      7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
      7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00
   };

   localparam logic [6:0] SHIFT_MAP [0:MAP_DEPTH-1] = '{
      7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
      7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
      7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00,
      7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
      7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
      7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00
   };

endpackage

// File: hdl/scle_front.sv
module scle_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [scle_pkg::REQ_WIDTH-1:0] req_tdata,
   input  scle_pkg::queue_status_type   qstat,
   output logic                         push,
   output scle_pkg::cmd_type            cmd
);
   import scle_pkg::*;

   logic             alt_ff, alt_in;
   logic [2:0]       fkey_ff, fkey_in;
   logic             ctrl_ff, ctrl_in;
   logic             shift_ff, shift_in;
   logic             caps_ff, caps_in;
   logic [7:0]       line_count_ff [NUM_TERMS];
   logic [NUM_TERMS-1:0] full_ff;
   logic [7:0]       line_count_in;
   logic             full_mark_in;

   logic [7:0] code;
   logic [1:0] disp;
   logic [1:0] run;
   logic       reading;
   logic       fire;
   logic       has_cmd;
   logic [7:0] count_disp;
   logic [5:0] key_idx;
   logic [6:0] plain_ch;
   logic [6:0] key_ch;
   logic [7:0] last_pos;
   logic [1:0] target;

   assign code    = req_tdata[7:0];
   assign disp    = (req_tdata[9:8] == 2'd3) ? 2'd2 : req_tdata[9:8];
   assign run     = (req_tdata[11:10] == 2'd3) ? 2'd2 : req_tdata[11:10];
   assign reading = req_tdata[12];

   assign req_tready = qstat.can_push;
   assign fire       = req_tvalid && req_tready;
   assign push       = fire && has_cmd;

   assign count_disp = line_count_ff[disp];
   assign key_idx    = code[5:0];
   assign plain_ch   = PLAIN_MAP[key_idx];

   always_comb begin
      if (shift_in) begin
         key_ch = SHIFT_MAP[key_idx];
      end else if (caps_in && (plain_ch inside {[7'h61:7'h7A]})) begin
         key_ch = plain_ch - 7'h20;
      end else begin
         key_ch = plain_ch;
      end
   end

   // tab covers four positions, anything else one
   assign last_pos = (code == SC_TAB) ? count_disp + 8'd3 : count_disp;

   always_comb begin
      alt_in = alt_ff;
      if (code == SC_ALT_DOWN) alt_in = 1'b1;
      if (code == SC_ALT_UP) alt_in = 1'b0;
      fkey_in = fkey_ff;
      if (code == SC_F1_DOWN) fkey_in[0] = 1'b1;
      if (code == SC_F1_UP) fkey_in[0] = 1'b0;
      if (code == SC_F2_DOWN) fkey_in[1] = 1'b1;
      if (code == SC_F2_UP) fkey_in[1] = 1'b0;
      if (code == SC_F3_DOWN) fkey_in[2] = 1'b1;
      if (code == SC_F3_UP) fkey_in[2] = 1'b0;
      target = fkey_in[2] ? 2'd2 : (fkey_in[1] ? 2'd1 : 2'd0);

      ctrl_in       = ctrl_ff;
      shift_in      = shift_ff;
      caps_in       = caps_ff;
      line_count_in = count_disp;
      full_mark_in  = full_ff[disp];
      has_cmd       = 1'b0;
      cmd           = '0;
      cmd.term      = disp;

      if (alt_in) begin
         if (fkey_in != 3'd0) begin
            has_cmd   = 1'b1;
            cmd.kind  = EV_SWITCH;
            cmd.term  = target;
            cmd.full  = full_ff[target];
         end
      end else begin
         if (code == SC_CTRL_DOWN) ctrl_in = 1'b1;
         if (code == SC_CTRL_UP) ctrl_in = 1'b0;
         if (ctrl_in) begin
            if (code == SC_KEY_L) begin
               has_cmd  = 1'b1;
               cmd.kind = EV_CLEAR;
               cmd.full = full_ff[disp];
            end else if (code == SC_KEY_C) begin
               has_cmd       = 1'b1;
               cmd.kind      = EV_INTERRUPT;
               cmd.halt      = (run == disp);
               line_count_in = 8'd0;
               full_mark_in  = 1'b0;
            end
         end else if (reading && (count_disp < LINE_LIMIT || code == SC_ENTER
                                  || code == SC_BACKSPACE)) begin
            if (code == SC_CAPS) caps_in = ~caps_ff;
            if (code == SC_LSHIFT_DOWN || code == SC_RSHIFT_DOWN) shift_in = 1'b1;
            if (code == SC_LSHIFT_UP || code == SC_RSHIFT_UP) shift_in = 1'b0;
            case (code)
               SC_ENTER: begin
                  has_cmd       = 1'b1;
                  cmd.kind      = EV_LINE_DONE;
                  cmd.pos       = count_disp;
                  line_count_in = 8'd0;
                  full_mark_in  = 1'b0;
               end
               SC_SPACE, SC_TAB: begin
                  has_cmd       = 1'b1;
                  cmd.kind      = EV_STORE;
                  cmd.is_append = 1'b1;
                  cmd.quad      = (code == SC_TAB);
                  cmd.chr       = CH_SPACE;
                  cmd.pos       = count_disp;
                  cmd.full      = full_ff[disp];
                  line_count_in = last_pos + 8'd1;
                  full_mark_in  = full_ff[disp] | (last_pos >= LINE_LIMIT);
               end
               SC_BACKSPACE: begin
                  if (count_disp != 8'd0) begin
                     has_cmd       = 1'b1;
                     cmd.kind      = EV_ERASE;
                     cmd.pos       = count_disp - 8'd1;
                     line_count_in = count_disp - 8'd1;
                     if (line_count_in < LINE_LIMIT) begin
                        full_mark_in = 1'b0;
                        cmd.valid    = 1'b1;
                     end
                     cmd.full = full_mark_in;
                  end
               end
               default: begin
                  if (code < 8'(KEY_COUNT) && key_ch != 7'd0) begin
                     has_cmd       = 1'b1;
                     cmd.kind      = EV_STORE;
                     cmd.is_append = 1'b1;
                     cmd.chr       = key_ch;
                     cmd.pos       = count_disp;
                     cmd.full      = full_ff[disp];
                     line_count_in = count_disp + 8'd1;
                     full_mark_in  = full_ff[disp] | (count_disp >= LINE_LIMIT);
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_ff   <= 1'b0;
         fkey_ff  <= 3'd0;
         ctrl_ff  <= 1'b0;
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         full_ff  <= '0;
         for (int i = 0; i < NUM_TERMS; i++) begin
            line_count_ff[i] <= 8'd0;
         end
      end else if (fire) begin
         alt_ff              <= alt_in;
         fkey_ff             <= fkey_in;
         ctrl_ff             <= ctrl_in;
         shift_ff            <= shift_in;
         caps_ff             <= caps_in;
         line_count_ff[disp] <= line_count_in;
         full_ff[disp]       <= full_mark_in;
      end
   end

endmodule

// File: hdl/scle_queue.sv
module scle_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  scle_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output scle_pkg::cmd_type          head,
   output scle_pkg::queue_status_type qstat
);
   import scle_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   assign head             = entry_ff[rd_ptr_ff];
   assign qstat.head_valid = (count_ff != '0);
   assign qstat.can_push   = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: hdl/scle_back.sv
module scle_back (
   input  logic                       clock,
   input  logic                       reset,
   input  scle_pkg::cmd_type          head,
   input  scle_pkg::queue_status_type qstat,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output scle_pkg::result_type       result
);
   import scle_pkg::*;

   logic       rsp_valid_ff;
   logic [1:0] step_ff, step_in;
   result_type result_ff, result_in;
   logic       load;
   logic       last_step;
   logic [7:0] step_pos;

   assign load      = qstat.head_valid && (!rsp_valid_ff || rsp_tready);
   assign last_step = !head.quad || (step_ff == 2'd3);
   assign pop       = load && last_step;
   assign step_pos  = head.pos + {6'd0, step_ff};
   assign step_in   = last_step ? 2'd0 : step_ff + 2'd1;

   always_comb begin
      result_in.kind  = head.kind;
      result_in.term  = head.term;
      result_in.chr   = head.chr;
      result_in.halt  = head.halt;
      result_in.last  = last_step;
      result_in.pos   = head.pos;
      result_in.valid = head.valid;
      result_in.full  = head.full;
      // each appended character sees the full flag as it stands after it
      if (head.is_append) begin
         result_in.pos   = step_pos;
         result_in.valid = step_pos < LINE_LIMIT;
         result_in.full  = head.full | (step_pos >= LINE_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= step_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign result     = result_ff;

endmodule

// File: hdl/scancode_line_editor.sv
// Set-1 scan codes in, line-editing events out. A request is taken in any cycle in which
// the four-entry command queue has room, so requests can arrive back to back. Each
// request yields zero to four results, one per cycle on the result port while rsp_tready
// is high: tab gives four, most other keys one, modifiers and dropped keys none. The
// result port therefore sets the sustained rate. The first result of a request passes
// through the command queue and then the result register before it is valid on the
// result port. The line buffer itself is not here; store and erase results carry the
// terminal, position and character to write.
module scancode_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // scan_code[7:0], display_terminal[9:8], running_terminal[11:10],
   // reading_enabled[12], zero[15:13]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // terminal_index[1:0], char_code[8:2], line_position[16:9], store_valid[17],
   // line_full[18], halt_now[19], zero[23:20]
   output logic [23:0] rsp_tdata,
   // event_kind[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import scle_pkg::*;

   queue_status_type qstat;
   cmd_type          push_cmd;
   cmd_type          head;
   result_type       result;
   logic             push;
   logic             pop;

   scle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push),
      .cmd        (push_cmd)
   );

   scle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   scle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {4'd0, result.halt, result.full, result.valid, result.pos,
                       result.chr, result.term};
   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.last;

   // a write the line buffer acts on always lands inside the line
   a_store_in_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.valid |-> result.pos < LINE_LIMIT)
      else $error("store or erase outside the line");

   a_char_only_on_store: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.kind != EV_STORE |-> result.chr == 7'd0)
      else $error("character on a non-store result");

   a_halt_only_on_intr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.halt |-> result.kind == EV_INTERRUPT)
      else $error("halt outside an interrupt");

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> qstat.can_push)
      else $error("command queue overflow");

endmodule

// File: verif/scancode_line_editor_test.sv
`timescale 1ns / 100ps

module scancode_line_editor_test;
   import scle_pkg::*;

   localparam logic [7:0] SC_ESCAPE = 8'h01;
   localparam int TARGET_ITEMS = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   bit quiet = 1'b0;
   int stall_left = 0;
   int sent_items = 0;

   scancode_line_editor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // keyboard state of the editor and the line events it should produce
   class line_event_board;
      bit         alt;
      bit [2:0]   fkeys;
      bit         ctrl;
      bit         shift;
      bit         caps;
      int         count [3];
      bit         full [3];
      string      plain_keys;
      string      shift_keys;
      result_type batch [$];
      result_type pending_events [$];
      int         mismatches;

      function new();
         // blank stands for a key without a character
         plain_keys = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./";
         shift_keys = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>?";
         alt = 0;
         fkeys = '0;
         ctrl = 0;
         shift = 0;
         caps = 0;
         mismatches = 0;
         for (int t = 0; t < 3; t++) begin
            count[t] = 0;
            full[t] = 0;
         end
      endfunction

      function void report(string msg);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, msg);
      endfunction

      function void add_event(event_kind_type kind, int term, logic [6:0] chr, int pos,
                              bit valid, bit halt);
         result_type e;
         e.kind = kind;
         e.term = term[1:0];
         e.chr = chr;
         e.pos = pos[7:0];
         e.valid = valid;
         e.full = full[term];
         e.halt = halt;
         e.last = 1'b0;
         batch.push_back(e);
      endfunction

      function void append_char(int term, logic [6:0] chr);
         int cnt;
         bit valid;
         cnt = count[term];
         valid = cnt < LINE_LENGTH;
         if (!valid) full[term] = 1;
         if (cnt < 255) count[term] = cnt + 1;
         add_event(EV_STORE, term, chr, cnt, valid, 1'b0);
      endfunction

      function void take_scan_code(logic [15:0] data);
         logic [7:0]   code;
         int           shown;
         int           sched;
         bit           reading;
         byte unsigned ch;
         int           pos;
         code = data[7:0];
         shown = data[9:8];
         sched = data[11:10];
         reading = data[12];
         if (shown > 2) shown = 2;
         if (sched > 2) sched = 2;
         batch.delete();

         if (code == SC_ALT_DOWN) alt = 1;
         if (code == SC_ALT_UP) alt = 0;
         if (code == SC_F1_DOWN) fkeys[0] = 1;
         if (code == SC_F1_UP) fkeys[0] = 0;
         if (code == SC_F2_DOWN) fkeys[1] = 1;
         if (code == SC_F2_UP) fkeys[1] = 0;
         if (code == SC_F3_DOWN) fkeys[2] = 1;
         if (code == SC_F3_UP) fkeys[2] = 0;

         if (alt) begin
            // switch goes to the highest held function key
            if (fkeys != 0)
               add_event(EV_SWITCH, fkeys[2] ? 2 : (fkeys[1] ? 1 : 0), '0, 0, 0, 0);
         end else begin
            if (code == SC_CTRL_DOWN) ctrl = 1;
            if (code == SC_CTRL_UP) ctrl = 0;
            if (ctrl) begin
               if (code == SC_KEY_L) begin
                  add_event(EV_CLEAR, shown, '0, 0, 0, 0);
               end else if (code == SC_KEY_C) begin
                  count[shown] = 0;
                  full[shown] = 0;
                  add_event(EV_INTERRUPT, shown, '0, 0, 0, sched == shown);
               end
            end else if (reading && !(count[shown] >= LINE_LENGTH && code != SC_ENTER &&
                                      code != SC_BACKSPACE)) begin
               if (code == SC_CAPS) caps = !caps;
               if (code == SC_LSHIFT_DOWN || code == SC_RSHIFT_DOWN) shift = 1;
               if (code == SC_LSHIFT_UP || code == SC_RSHIFT_UP) shift = 0;
               if (code == SC_ENTER) begin
                  pos = count[shown];
                  count[shown] = 0;
                  full[shown] = 0;
                  add_event(EV_LINE_DONE, shown, '0, pos, 0, 0);
               end else if (code == SC_SPACE) begin
                  append_char(shown, CH_SPACE);
               end else if (code == SC_TAB) begin
                  for (int i = 0; i < 4; i++) append_char(shown, CH_SPACE);
               end else if (code == SC_BACKSPACE) begin
                  if (count[shown] > 0) begin
                     pos = count[shown] - 1;
                     count[shown] = pos;
                     if (pos < LINE_LENGTH) full[shown] = 0;
                     add_event(EV_ERASE, shown, '0, pos, pos < LINE_LENGTH, 0);
                  end
               end else if (code != SC_ESCAPE && code < KEY_COUNT) begin
                  ch = shift ? shift_keys[code] : plain_keys[code];
                  if (caps && !shift && ch >= "a" && ch <= "z") ch = ch - 8'd32;
                  if (ch != " ") append_char(shown, ch[6:0]);
               end
            end
         end

         if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
         end
         foreach (batch[i]) pending_events.push_back(batch[i]);
      endfunction

      function void compare(string field, int got, int want);
         if (got != want)
            report($sformatf("%s got %0d expected %0d", field, got, want));
      endfunction

      function void check_event(logic [23:0] data, logic [2:0] kind, logic last);
         result_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected result kind %0d data %h", kind, data));
            return;
         end
         want = pending_events.pop_front();
         compare("event_kind", kind, want.kind);
         compare("terminal_index", data[1:0], want.term);
         compare("char_code", data[8:2], want.chr);
         compare("line_position", data[16:9], want.pos);
         compare("store_valid", data[17], want.valid);
         compare("line_full", data[18], want.full);
         compare("halt_now", data[19], want.halt);
         compare("last_result", last, want.last);
      endfunction
   endclass

   line_event_board board = new();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 88) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_event(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) board.take_scan_code(req_tdata);
      end
   end

   task automatic send_request(input logic [15:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic press(input logic [7:0] code, input int shown, input int sched = 0,
                        input bit reading = 1'b1);
      send_request({3'b000, reading, sched[1:0], shown[1:0], code});
   endtask

   // hold the sender off until every expected result is out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_events.size() != 0);
   endtask

   function automatic logic [7:0] typing_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 8'($urandom_range(0, KEY_COUNT - 1));
      else if (r < 65) return SC_SPACE;
      else if (r < 75) return SC_TAB;
      else if (r < 83) return SC_BACKSPACE;
      else if (r < 86) return SC_ENTER;
      else if (r < 90) return $urandom_range(0, 1) ? SC_LSHIFT_DOWN : SC_RSHIFT_DOWN;
      else if (r < 94) return $urandom_range(0, 1) ? SC_LSHIFT_UP : SC_RSHIFT_UP;
      else if (r < 97) return SC_CAPS;
      else return 8'h80 | 8'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] fkey_code();
      case ($urandom_range(0, 6))
         0: return SC_F1_DOWN;
         1: return SC_F1_UP;
         2: return SC_F2_DOWN;
         3: return SC_F2_UP;
         4: return SC_F3_DOWN;
         5: return SC_F3_UP;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic run_burst(input int kind);
      int term;
      int sched;
      int n;
      term = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2);
      sched = $urandom_range(0, 3);
      case (kind)
         0: begin
            if ($urandom_range(0, 2) == 0) begin
               press(SC_ALT_UP, term, sched);
               press(SC_CTRL_UP, term, sched);
            end
            n = $urandom_range(4, 20);
            repeat (n) press(typing_code(), term, sched, $urandom_range(0, 9) != 0);
         end
         1: begin
            // run a line past its end, then back it off again
            press(SC_ALT_UP, term, sched);
            press(SC_CTRL_UP, term, sched);
            repeat ($urandom_range(0, 3)) press(8'($urandom_range(16, 25)), term, sched);
            repeat (33) press(SC_TAB, term, sched);
            repeat ($urandom_range(0, 3)) press(typing_code(), term, sched);
            repeat ($urandom_range(1, 8)) press(SC_BACKSPACE, term, sched);
            if ($urandom_range(0, 1)) press(SC_ENTER, term, sched);
         end
         2: begin
            press(SC_CTRL_DOWN, term, sched, $urandom_range(0, 1));
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 2))
                  0: press(SC_KEY_L, $urandom_range(0, 3), $urandom_range(0, 3));
                  1: press(SC_KEY_C, $urandom_range(0, 3), $urandom_range(0, 3));
                  default: press(8'($urandom_range(0, 255)), term, sched,
                                 $urandom_range(0, 1));
               endcase
            end
            if ($urandom_range(0, 4) != 0) press(SC_CTRL_UP, term, sched);
         end
         3: begin
            press(SC_ALT_DOWN, term, sched, $urandom_range(0, 1));
            repeat ($urandom_range(1, 5))
               press(fkey_code(), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 1));
            if ($urandom_range(0, 4) != 0) press(SC_ALT_UP, term, sched);
         end
         default: begin
            repeat ($urandom_range(1, 6))
               press(8'($urandom_range(0, 255)), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 1));
         end
      endcase
   endtask

   initial begin
      int r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      press(8'h02, 0);
      press(SC_LSHIFT_DOWN, 0);
      press(8'h02, 0);
      press(SC_RSHIFT_DOWN, 1);
      press(8'h35, 1);
      press(SC_RSHIFT_UP, 1);
      press(SC_CAPS, 0);
      press(8'h10, 0);
      press(SC_CAPS, 0);
      press(SC_SPACE, 0);
      press(SC_TAB, 0);
      press(SC_BACKSPACE, 0);
      press(SC_ESCAPE, 0);
      press(8'hFF, 0);
      press(8'h05, 0, 0, 1'b0);
      press(SC_ENTER, 0);
      press(SC_BACKSPACE, 2);
      press(SC_CTRL_DOWN, 0);
      press(SC_KEY_L, 1);
      press(SC_KEY_C, 2, 2);
      press(SC_KEY_C, 3, 0);
      press(SC_CTRL_UP, 0);
      press(SC_ALT_DOWN, 0);
      press(SC_F1_DOWN, 0);
      press(SC_F3_DOWN, 0);
      press(SC_F3_UP, 0);
      press(SC_F2_DOWN, 0);
      press(SC_ALT_UP, 0);

      wait_drained();
      run_burst(1);
      while (sent_items < TARGET_ITEMS) begin
         quiet = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 9) == 0) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 45) run_burst(0);
         else if (r < 53) run_burst(1);
         else if (r < 68) run_burst(2);
         else if (r < 83) run_burst(3);
         else run_burst(4);
      end
      quiet = 1'b0;

      wait_drained();
      repeat (20) @(posedge clock);
      if (board.pending_events.size() != 0)
         board.report($sformatf("%0d results never came", board.pending_events.size()));
      if (board.mismatches == 0) begin
         $display("** scancode_line_editor: PASSED **");
      end else begin
         $display("** scancode_line_editor: FAILED **");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("** scancode_line_editor: FAILED **");
      $finish;
   end

endmodule

// File: scancode_line_editor.f
hdl/scle_pkg.sv
hdl/scle_front.sv
hdl/scle_queue.sv
hdl/scle_back.sv
hdl/scancode_line_editor.sv
verif/scancode_line_editor_test.sv
